// ===== sv/lpg_pkg.sv =====
// Shared types, constants and the arctangent table of the light pair geometry classifier.
package lpg_pkg;

  // Working widths of the datapath.
  localparam int DXW = 17;
  localparam int ZW = 20;
  localparam int XW = 33;
  localparam int CORDIC_STEPS = 16;

  // Fixed-point constants.
  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [16:0] DEG_PER_RAD = 17'd117342;
  localparam logic [33:0] ROUND_HALF = 34'd32768;
  localparam logic [16:0] FOLD_FULL = 17'd46080;
  localparam logic [16:0] FOLD_HALF = 17'd23040;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [15:0] THRESHOLD_RESET = 16'd819;

  // Input word: one candidate pair of light bars.
  typedef struct packed {
    logic [15:0] left_center_x;
    logic [15:0] left_center_y;
    logic [15:0] left_length;
    logic signed [15:0] left_angle;
    logic [15:0] right_center_x;
    logic [15:0] right_center_y;
    logic [15:0] right_length;
    logic signed [15:0] right_angle;
  } in_word_t;

  // Output word: the pair's features.
  typedef struct packed {
    logic [14:0] angle_difference;
    logic [16:0] length_ratio;
    logic [15:0] across_ratio;
    logic [15:0] along_ratio;
    logic [15:0] closeness_ratio;
    logic is_large;
  } out_word_t;

  // Queue word: the classified pair as the front hands it to the back.
  typedef struct packed {
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic [15:0] d13;
    logic [15:0] mn;
    logic [15:0] mx;
    logic [16:0] len_sum;
    logic len_zero;
    logic signed [ZW-1:0] z;
  } q_word_t;

  // Arctangent of 2^-i in radians Q.16.
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 20'sd51472;
      1: a = 20'sd30386;
      2: a = 20'sd16055;
      3: a = 20'sd8150;
      4: a = 20'sd4091;
      5: a = 20'sd2047;
      6: a = 20'sd1024;
      7: a = 20'sd512;
      8: a = 20'sd256;
      9: a = 20'sd128;
      10: a = 20'sd64;
      11: a = 20'sd32;
      12: a = 20'sd16;
      13: a = 20'sd8;
      14: a = 20'sd4;
      15: a = 20'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/light_pair_geometry_classifier.sv =====
// Light pair geometry classifier: front classifier, word queue, feature pipeline.
//
// Usage: a pair word enters on pair/pair_valid and is taken at a rising edge where
// pair_valid is high and pair_stall is low. The feature word leaves on
// feat/feat_valid and is taken at an edge where feat_valid is high and feat_stall
// is low. One feature word comes out per pair word, in order.
// With an empty queue and no stall, the square root (25 stages) followed by the
// closeness divider (16 stages) sets the depth between taking a pair word and its
// feature word. Throughput is one word per cycle while the output is not stalled.
// A stalled output freezes the feature pipeline; the queue (QUEUE_DEPTH words)
// keeps taking pair words until it fills, then pair_stall rises.
// cfg_write with cfg_data loads the large-type threshold (Q8.8); write it only
// while no word is in flight.
// Reset (rst, synchronous) empties the queue and pipeline and sets the
// threshold to 819.
module light_pair_geometry_classifier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  lpg_pkg::in_word_t  pair,
  output logic               feat_valid,
  input  logic               feat_stall,
  output lpg_pkg::out_word_t feat,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  logic [15:0]      threshold;
  lpg_pkg::q_word_t cls;
  lpg_pkg::q_word_t head;
  logic             head_valid;
  logic             pop;
  logic             full;
  logic             push;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= lpg_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  lpg_front u_front (
    .pair(pair), .cls(cls)
  );

  // A pair word is taken whenever the queue has room.
  assign push = pair_valid && !full;
  assign pair_stall = full;

  lpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_word(cls), .full(full),
    .pop(pop), .head_word(head), .head_valid(head_valid)
  );

  lpg_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .pop(pop),
    .threshold(threshold), .res_valid(feat_valid), .res_stall(feat_stall),
    .res_word(feat)
  );

endmodule

// ===== sv/lpg_front.sv =====
// Front classifier: turns an input word into the differences and folded angle the back needs.
module lpg_front (
  input  lpg_pkg::in_word_t pair,
  output lpg_pkg::q_word_t  cls
);

  logic signed [16:0] dang;
  logic [16:0] dang_abs;
  logic signed [lpg_pkg::ZW-1:0] z_raw;

  // Center offsets of the right bar from the left bar.
  assign cls.dx = $signed({1'b0, pair.right_center_x}) - $signed({1'b0, pair.left_center_x});
  assign cls.dy = $signed({1'b0, pair.right_center_y}) - $signed({1'b0, pair.left_center_y});

  // Magnitude of the angle difference in Q3.13.
  assign dang = {pair.left_angle[15], pair.left_angle} - {pair.right_angle[15], pair.right_angle};
  assign dang_abs = dang[16] ? 17'(-dang) : dang;
  assign cls.d13 = dang_abs[15:0];

  // Shorter and longer length, and their sum.
  assign cls.mn = (pair.left_length < pair.right_length) ? pair.left_length : pair.right_length;
  assign cls.mx = (pair.left_length < pair.right_length) ? pair.right_length : pair.left_length;
  assign cls.len_sum = {1'b0, pair.left_length} + {1'b0, pair.right_length};
  assign cls.len_zero = (cls.mx == 16'd0);

  // Left angle in Q.16, moved by pi into the half plane the rotation covers.
  assign z_raw = {pair.left_angle[15], pair.left_angle, 3'b000};
  always_comb begin
    if (z_raw > lpg_pkg::HALF_PI_Q16) begin
      cls.z = z_raw - lpg_pkg::PI_Q16;
    end else if (z_raw < -lpg_pkg::HALF_PI_Q16) begin
      cls.z = z_raw + lpg_pkg::PI_Q16;
    end else begin
      cls.z = z_raw;
    end
  end

endmodule

// ===== sv/lpg_queue.sv =====
// Short queue of classified words between the front and the back.
module lpg_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpg_pkg::q_word_t  push_word,
  output logic              full,
  input  logic              pop,
  output lpg_pkg::q_word_t  head_word,
  output logic              head_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpg_pkg::q_word_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_word = mem[rd_ptr];

endmodule

// ===== sv/lpg_delay.sv =====
// Enabled delay line that keeps side values in step with the long units.
module lpg_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [N];

  // Shift one place per advancing cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < N; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign q = pipe[N-1];

endmodule

// ===== sv/lpg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; needs num < den * 2^QW.
module lpg_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [W-1:0]  shd;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // Try the shifted divisor against the partial remainder.
    assign shd = W'(den_in) << (QW - 1 - i);
    assign take = (rem_in >= shd);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[i] <= quo_in | (QW'(take) << (QW - 1 - i));
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? rem_in - shd : rem_in;
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== sv/lpg_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module lpg_sqrt #(
  parameter int NW = 50
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     val,
  output logic [NW/2-1:0]   root
);

  localparam int RW = NW / 2;

  logic [NW-1:0] v_q [RW-1];
  logic [NW:0]   r_q [RW-1];
  logic [RW-1:0] root_q;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [NW-1:0] v_in;
    logic [NW:0]   r_in;
    logic [NW:0]   bit_v;
    logic [NW:0]   rb;
    logic [NW:0]   r_next;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in = val;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    // Test the next power of four against the remainder.
    assign bit_v = (NW + 1)'(1) << (2 * (RW - 1 - k));
    assign rb = r_in + bit_v;
    assign take = ({1'b0, v_in} >= rb);
    assign r_next = take ? (r_in >> 1) + bit_v : r_in >> 1;

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          v_q[k] <= take ? v_in - rb[NW-1:0] : v_in;
          r_q[k] <= r_next;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          root_q <= r_next[RW-1:0];
        end
      end
    end
  end

  assign root = root_q;

endmodule

// ===== sv/lpg_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine in Q1.30, one iteration per stage.
module lpg_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lpg_pkg::ZW-1:0]    angle,
  output logic signed [lpg_pkg::XW-1:0]    sin_v,
  output logic signed [lpg_pkg::XW-1:0]    cos_v
);

  localparam int N = lpg_pkg::CORDIC_STEPS;

  logic signed [lpg_pkg::XW-1:0] x_q [N];
  logic signed [lpg_pkg::XW-1:0] y_q [N];
  logic signed [lpg_pkg::ZW-1:0] z_q [N-1];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [lpg_pkg::XW-1:0] x_in;
    logic signed [lpg_pkg::XW-1:0] y_in;
    logic signed [lpg_pkg::XW-1:0] xs;
    logic signed [lpg_pkg::XW-1:0] ys;
    logic signed [lpg_pkg::ZW-1:0] z_in;
    logic signed [lpg_pkg::ZW-1:0] da;
    logic                          ccw;

    if (i == 0) begin : g_first
      assign x_in = lpg_pkg::CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = angle;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    // Rotate toward zero residual angle.
    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign da = lpg_pkg::atan_q16(i);
    assign ccw = !z_in[lpg_pkg::ZW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[i] <= ccw ? x_in - ys : x_in + ys;
        y_q[i] <= ccw ? y_in + xs : y_in - xs;
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_q[i] <= ccw ? z_in - da : z_in + da;
        end
      end
    end
  end

  assign cos_v = x_q[N-1];
  assign sin_v = y_q[N-1];

endmodule

// ===== sv/lpg_back.sv =====
// Back pipeline: computes all pair features, one queue word per cycle unless stalled.
module lpg_back (
  input  logic               clk,
  input  logic               rst,
  input  lpg_pkg::q_word_t   head,
  input  logic               head_valid,
  output logic               pop,
  input  logic [15:0]        threshold,
  output logic               res_valid,
  input  logic               res_stall,
  output lpg_pkg::out_word_t res_word
);

  // Stage map: a value is "at stage k" when it sits in the k-th register after the queue.
  localparam int RQW = 16;
  localparam int LQW = 17;
  localparam int SQ_IN_W = 50;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int S_CORD = lpg_pkg::CORDIC_STEPS;
  localparam int S_ABS = S_CORD + 3;
  localparam int S_RATIO = S_ABS + RQW;
  localparam int S_ROOT = 2 + SQ_STEPS;
  localparam int S_LARGE = S_ROOT + 1;
  localparam int S_FOLD = 3;
  localparam int LAST = S_ROOT + RQW;

  logic en;
  logic [LAST:1] vld;

  // The whole pipe moves unless a finished word waits at a stalled output.
  assign en = !res_valid || !res_stall;
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], pop};
      res_valid <= vld[LAST];
    end
  end

  // Angle difference in degrees, rounded, then folded about 180.
  logic [32:0] deg_prod;
  logic [16:0] deg;
  logic [14:0] fold;
  logic [14:0] fold_out;

  always_ff @(posedge clk) begin
    if (en) begin
      deg_prod <= 33'(head.d13) * 33'(lpg_pkg::DEG_PER_RAD);
      deg <= 17'((34'(deg_prod) + lpg_pkg::ROUND_HALF) >> 16);
      if (deg <= lpg_pkg::FOLD_HALF) begin
        fold <= deg[14:0];
      end else if (deg >= lpg_pkg::FOLD_FULL) begin
        fold <= '0;
      end else begin
        fold <= 15'(lpg_pkg::FOLD_FULL - deg);
      end
    end
  end

  lpg_delay #(.W(15), .N(LAST - S_FOLD)) u_fold_dly (
    .clk(clk), .en(en), .d(fold), .q(fold_out)
  );

  // Length ratio: shorter over longer.
  logic [LQW-1:0] lr_quo;
  logic           lz_17;
  logic [LQW-1:0] lr_sel;
  logic [LQW-1:0] lr_out;

  lpg_div #(.NW(32), .DW(16), .QW(LQW)) u_len_div (
    .clk(clk), .en(en), .num({head.mn, 16'd0}), .den(head.mx), .quo(lr_quo)
  );

  lpg_delay #(.W(1), .N(LQW)) u_lz_dly (
    .clk(clk), .en(en), .d(head.len_zero), .q(lz_17)
  );

  assign lr_sel = lz_17 ? '0 : lr_quo;

  lpg_delay #(.W(LQW), .N(LAST - LQW)) u_lr_dly (
    .clk(clk), .en(en), .d(lr_sel), .q(lr_out)
  );

  // Sine and cosine of the left angle, with the offsets held alongside.
  logic signed [lpg_pkg::XW-1:0] sn;
  logic signed [lpg_pkg::XW-1:0] cs;
  logic [2*lpg_pkg::DXW-1:0]     dxy_c;
  logic signed [lpg_pkg::DXW-1:0] dx_c;
  logic signed [lpg_pkg::DXW-1:0] dy_c;

  lpg_cordic u_cordic (
    .clk(clk), .en(en), .angle(head.z), .sin_v(sn), .cos_v(cs)
  );

  lpg_delay #(.W(2 * lpg_pkg::DXW), .N(S_CORD)) u_dxy_dly (
    .clk(clk), .en(en), .d({head.dx, head.dy}), .q(dxy_c)
  );

  assign dx_c = $signed(dxy_c[2*lpg_pkg::DXW-1:lpg_pkg::DXW]);
  assign dy_c = $signed(dxy_c[lpg_pkg::DXW-1:0]);

  // Offsets across and along the left bar: products, sums, magnitudes.
  logic signed [49:0] p_dx_sn;
  logic signed [49:0] p_dy_cs;
  logic signed [49:0] p_dx_cs;
  logic signed [49:0] p_dy_sn;
  logic signed [50:0] across_s;
  logic signed [50:0] along_s;
  logic [49:0]        across_n;
  logic [49:0]        along_n;

  always_ff @(posedge clk) begin
    if (en) begin
      p_dx_sn <= dx_c * sn;
      p_dy_cs <= dy_c * cs;
      p_dx_cs <= dx_c * cs;
      p_dy_sn <= dy_c * sn;
      across_s <= {p_dy_cs[49], p_dy_cs} - {p_dx_sn[49], p_dx_sn};
      along_s <= {p_dx_cs[49], p_dx_cs} + {p_dy_sn[49], p_dy_sn};
      across_n <= across_s[50] ? 50'(-across_s) : across_s[49:0];
      along_n <= along_s[50] ? 50'(-along_s) : along_s[49:0];
    end
  end

  // Offsets over the mean length, with saturation and the zero-length case.
  logic [16:0]    sum_19;
  logic           sum19_zero;
  logic [37:0]    ratio_den;
  logic [53:0]    ratio_lim;
  logic [3:0]     rflag_19;
  logic [3:0]     rflag_35;
  logic [RQW-1:0] across_q;
  logic [RQW-1:0] along_q;
  logic [15:0]    across_sel;
  logic [15:0]    along_sel;
  logic [31:0]    ratio_out;

  lpg_delay #(.W(17), .N(S_ABS)) u_sum19_dly (
    .clk(clk), .en(en), .d(head.len_sum), .q(sum_19)
  );

  assign sum19_zero = (sum_19 == 17'd0);
  assign ratio_den = {sum_19, 21'd0};
  assign ratio_lim = {sum_19, 37'd0};

  // Flags: across forced high, across forced low, along forced high, along forced low.
  assign rflag_19[3] = sum19_zero ? (across_n != '0) : ({4'd0, across_n} >= ratio_lim);
  assign rflag_19[2] = sum19_zero && (across_n == '0);
  assign rflag_19[1] = sum19_zero ? (along_n != '0) : ({4'd0, along_n} >= ratio_lim);
  assign rflag_19[0] = sum19_zero && (along_n == '0);

  lpg_div #(.NW(50), .DW(38), .QW(RQW)) u_across_div (
    .clk(clk), .en(en), .num(across_n), .den(ratio_den), .quo(across_q)
  );

  lpg_div #(.NW(50), .DW(38), .QW(RQW)) u_along_div (
    .clk(clk), .en(en), .num(along_n), .den(ratio_den), .quo(along_q)
  );

  lpg_delay #(.W(4), .N(RQW)) u_rflag_dly (
    .clk(clk), .en(en), .d(rflag_19), .q(rflag_35)
  );

  assign across_sel = rflag_35[3] ? lpg_pkg::SAT16 : (rflag_35[2] ? 16'd0 : across_q);
  assign along_sel = rflag_35[1] ? lpg_pkg::SAT16 : (rflag_35[0] ? 16'd0 : along_q);

  lpg_delay #(.W(32), .N(LAST - S_RATIO)) u_ratio_dly (
    .clk(clk), .en(en), .d({across_sel, along_sel}), .q(ratio_out)
  );

  // Center distance: squared offsets, their sum, and the square root.
  logic signed [33:0]     sqx_full;
  logic signed [33:0]     sqy_full;
  logic [31:0]            sqx;
  logic [31:0]            sqy;
  logic [32:0]            d2;
  logic [SQ_STEPS-1:0]    s_27;

  assign sqx_full = head.dx * head.dx;
  assign sqy_full = head.dy * head.dy;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= sqx_full[31:0];
      sqy <= sqy_full[31:0];
      d2 <= {1'b0, sqx} + {1'b0, sqy};
    end
  end

  lpg_sqrt #(.NW(SQ_IN_W)) u_sqrt (
    .clk(clk), .en(en), .val({1'b0, d2, 16'd0}), .root(s_27)
  );

  // Mean length over distance.
  logic [16:0]    sum_27;
  logic           csat_27;
  logic           csat_out;
  logic [RQW-1:0] close_q;

  lpg_delay #(.W(17), .N(S_ROOT - S_ABS)) u_sum27_dly (
    .clk(clk), .en(en), .d(sum_19), .q(sum_27)
  );

  assign csat_27 = (s_27 == '0) || ({9'd0, sum_27} >= {s_27, 1'b0});

  lpg_div #(.NW(32), .DW(SQ_STEPS), .QW(RQW)) u_close_div (
    .clk(clk), .en(en), .num({sum_27, 15'd0}), .den(s_27), .quo(close_q)
  );

  lpg_delay #(.W(1), .N(RQW)) u_csat_dly (
    .clk(clk), .en(en), .d(csat_27), .q(csat_out)
  );

  // Large type: twice the distance against (threshold + 1) times the length sum.
  logic [33:0]         thr_prod;
  logic [SQ_STEPS-1:0] s_28;
  logic [16:0]         sum_28;
  logic                large_28;
  logic                large_out;

  always_ff @(posedge clk) begin
    if (en) begin
      thr_prod <= 34'({1'b0, threshold} + 17'd1) * 34'(sum_27);
    end
  end

  lpg_delay #(.W(SQ_STEPS), .N(1)) u_s28_dly (
    .clk(clk), .en(en), .d(s_27), .q(s_28)
  );

  lpg_delay #(.W(17), .N(1)) u_sum28_dly (
    .clk(clk), .en(en), .d(sum_27), .q(sum_28)
  );

  assign large_28 = (sum_28 == 17'd0) ? (s_28 != '0) : ({8'd0, s_28, 1'b0} >= thr_prod);

  lpg_delay #(.W(1), .N(LAST - S_LARGE)) u_large_dly (
    .clk(clk), .en(en), .d(large_28), .q(large_out)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res_word.angle_difference <= fold_out;
      res_word.length_ratio <= lr_out;
      res_word.across_ratio <= ratio_out[31:16];
      res_word.along_ratio <= ratio_out[15:0];
      res_word.closeness_ratio <= csat_out ? lpg_pkg::SAT16 : close_q;
      res_word.is_large <= large_out;
    end
  end

endmodule
